FILE: rtl/core/cbmt_pkg.sv
// Shared sizes and operation codes for the counter bank with max tracking.
package cbmt_pkg;

  localparam int NUM_COUNTERS = 16;
  localparam int COUNT_WIDTH  = 16;
  localparam int MAX_RESULTS  = 16;

  localparam int IDX_W  = $clog2(NUM_COUNTERS);
  localparam int PTR_W  = IDX_W + 1;
  localparam int HOLD_W = $clog2(NUM_COUNTERS + 1);
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);
  localparam int LIM_W  = (HOLD_W > RES_W) ? HOLD_W : RES_W;

  localparam logic [2:0] OP_INC  = 3'd0;
  localparam logic [2:0] OP_DEC  = 3'd1;
  localparam logic [2:0] OP_CLR  = 3'd2;
  localparam logic [2:0] OP_READ = 3'd3;
  localparam logic [2:0] OP_LIST = 3'd4;

  localparam logic signed [COUNT_WIDTH-1:0] COUNT_TOP =
    {1'b0, {(COUNT_WIDTH - 1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] COUNT_BOTTOM =
    {1'b1, {(COUNT_WIDTH - 1){1'b0}}};

endpackage

FILE: rtl/core/counter_bank_with_max_tracking_unit.sv
// Counter bank with max tracking: top level, sequencer, counter memory and scan unit.
//
// A bank of NUM_COUNTERS saturating signed counters held in a small memory with a
// registered read port, plus the largest value and how many counters hold it.
// Increment, decrement and clear read the named counter in the accept cycle, update
// it in MODIFY, then rebuild the tracked maximum by a full pass over the memory, one
// counter per cycle through a single shared compare unit, and present the item from
// FINISH once the output register is free. Read skips the pass.
// Listing walks the same memory port, one counter per cycle, and gives one item
// per counter at the maximum in ascending index order (at most 16), with last set
// on the final one; it stalls while the output register is held. The input side
// is taken only while the sequencer is idle; a finished item may still be waiting
// in the output register when the next one is accepted.
module counter_bank_with_max_tracking_unit
  import cbmt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic [3:0]         counter_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] count_value,
  output logic signed [15:0] max_value,
  output logic [4:0]         max_holders,
  output logic [3:0]         listed_index,
  output logic               last
);

  typedef enum logic [2:0] {
    IDLE,
    MODIFY,
    SCAN,
    LIST,
    FINISH
  } state_t;

  state_t state;

  // counter memory
  logic signed [COUNT_WIDTH-1:0] mem [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0]       vld;
  logic signed [COUNT_WIDTH-1:0] rd_data;
  logic [IDX_W-1:0]              raddr;
  logic                          rd_en;
  logic                          wr_en;
  logic signed [COUNT_WIDTH-1:0] wr_data;

  logic [2:0]                    op_q;
  logic [IDX_W-1:0]              idx_q;
  logic signed [COUNT_WIDTH-1:0] cv;
  logic signed [COUNT_WIDTH-1:0] largest;
  logic [HOLD_W-1:0]             holders;
  logic [PTR_W-1:0]              ptr;
  logic                          dvalid;
  logic [IDX_W-1:0]              didx;
  logic [LIM_W-1:0]              n_emit;

  logic                          out_free;
  logic                          out_load;
  logic                          match;
  logic                          stall;
  logic                          fetch_more;
  logic                          scan_end;
  logic                          out_of_range;
  logic [LIM_W-1:0]              lim;
  logic                          last_hit;

  assign in_ready     = (state == IDLE);
  assign out_free     = !out_valid || out_ready;
  assign match        = dvalid && (rd_data == largest);
  assign stall        = (state == LIST) && match && !out_free;
  assign out_load     = ((state == LIST) && match && out_free) ||
                        ((state == FINISH) && out_free);
  assign rd_en        = !stall;
  assign fetch_more   = (ptr < PTR_W'(NUM_COUNTERS));
  assign scan_end     = dvalid && (didx == IDX_W'(NUM_COUNTERS - 1));
  assign out_of_range = (32'(counter_index) >= 32'(NUM_COUNTERS));
  assign raddr        = (state == IDLE) ? IDX_W'(counter_index) : ptr[IDX_W-1:0];
  assign wr_en        = (state == MODIFY) &&
                        (op_q == OP_INC || op_q == OP_DEC || op_q == OP_CLR);

  assign lim      = (LIM_W'(holders) > LIM_W'(MAX_RESULTS)) ? LIM_W'(MAX_RESULTS)
                                                            : LIM_W'(holders);
  assign last_hit = ((n_emit + LIM_W'(1)) == lim);

  always_comb begin
    case (op_q)
      OP_INC:  wr_data = (rd_data != COUNT_TOP) ? rd_data + COUNT_WIDTH'(1) : rd_data;
      OP_DEC:  wr_data = (rd_data != COUNT_BOTTOM) ? rd_data - COUNT_WIDTH'(1) : rd_data;
      OP_CLR:  wr_data = '0;
      default: wr_data = rd_data;
    endcase
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= vld[raddr] ? mem[raddr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      largest   <= '0;
      holders   <= HOLD_W'(NUM_COUNTERS);
      ptr       <= '0;
      dvalid    <= 1'b0;
      n_emit    <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // shared fetch for both scan kinds
      if ((state == SCAN || state == LIST) && !stall) begin
        if (fetch_more) begin
          ptr    <= ptr + PTR_W'(1);
          dvalid <= 1'b1;
          didx   <= ptr[IDX_W-1:0];
        end else begin
          dvalid <= 1'b0;
        end
      end

      case (state)
        IDLE: begin
          if (in_valid) begin
            op_q   <= operation;
            idx_q  <= IDX_W'(counter_index);
            ptr    <= '0;
            dvalid <= 1'b0;
            n_emit <= '0;
            if (operation == OP_LIST) begin
              state <= LIST;
            end else if (out_of_range) begin
              cv    <= '0;
              state <= FINISH;
            end else begin
              state <= MODIFY;
            end
          end
        end

        MODIFY: begin
          cv <= wr_data;
          if (wr_en) begin
            state <= SCAN;
          end else begin
            state <= FINISH;
          end
        end

        SCAN: begin
          if (dvalid) begin
            if (didx == '0 || rd_data > largest) begin
              largest <= rd_data;
              holders <= HOLD_W'(1);
            end else if (rd_data == largest) begin
              holders <= holders + HOLD_W'(1);
            end
          end
          if (scan_end) begin
            state <= FINISH;
          end
        end

        LIST: begin
          if (match && out_free) begin
            count_value  <= 16'(rd_data);
            max_value    <= 16'(largest);
            max_holders  <= 5'(holders);
            listed_index <= 4'(didx);
            last         <= last_hit;
            n_emit       <= n_emit + LIM_W'(1);
            if (last_hit) begin
              state <= IDLE;
            end
          end else if (!stall && scan_end) begin
            state <= IDLE;
          end
        end

        FINISH: begin
          if (out_free) begin
            count_value  <= 16'(cv);
            max_value    <= 16'(largest);
            max_holders  <= 5'(holders);
            listed_index <= '0;
            last         <= 1'b1;
            state        <= IDLE;
          end
        end

        default: state <= IDLE;
      endcase
    end
  end

endmodule
